### rtl/dss_pkg.sv
// ----------------------------------------------------------------------------
// dss_pkg
// Shared types and constants of the disk seek scheduler.
// ----------------------------------------------------------------------------
package dss_pkg;

  localparam int MAX_REQ = 64;
  localparam int IDX_W   = $clog2(MAX_REQ);
  localparam int CNT_W   = IDX_W + 1;
  localparam int TRACK_W = 7;
  localparam int DIST_W  = 14;
  localparam int MODE_W  = 2;
  localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};
  localparam logic [TRACK_W-1:0] START_RESET = TRACK_W'(50);

  typedef enum logic [MODE_W-1:0] {
    MODE_FIFO = 2'd0,
    MODE_SSTF = 2'd1,
    MODE_SCAN = 2'd2,
    MODE_CSCAN = 2'd3
  } mode_t;

  typedef enum logic {
    REG_MODE = 1'b0,
    REG_START = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_LOAD = 2'b01,
    ST_SERVE = 2'b10
  } state_t;

  typedef struct packed {
    logic               valid;
    logic [IDX_W-1:0]   slot;
    logic [TRACK_W-1:0] track;
  } entry_t;

  typedef struct packed {
    logic               fu;
    logic [TRACK_W-1:0] gu;
    logic [IDX_W-1:0]   su;
    logic [TRACK_W-1:0] pu;
    logic               fd;
    logic [TRACK_W-1:0] gd;
    logic [IDX_W-1:0]   sd;
    logic [TRACK_W-1:0] pd;
    logic               fm;
    logic [TRACK_W-1:0] pm;
    logic [IDX_W-1:0]   sm;
    logic [TRACK_W-1:0] pc;
  } pick_t;

endpackage

### rtl/dss_if.sv
// ----------------------------------------------------------------------------
// dss_req_if / dss_svc_if
// Valid/ready channels for track requests and service results.
// ----------------------------------------------------------------------------
interface dss_req_if;
  logic       valid;
  logic       ready;
  logic [6:0] request_track;
  logic       last_request;
  modport source (output valid, request_track, last_request, input ready);
  modport sink (input valid, request_track, last_request, output ready);
endinterface

interface dss_svc_if;
  logic        valid;
  logic        ready;
  logic [6:0]  served_track;
  logic [5:0]  service_index;
  logic [13:0] cumulative_distance;
  logic        last_service;
  modport source (output valid, served_track, service_index, cumulative_distance,
                  last_service, input ready);
  modport sink (input valid, served_track, service_index, cumulative_distance,
                last_service, output ready);
endinterface

### rtl/dss_cell.sv
// ----------------------------------------------------------------------------
// dss_cell
// One ring cell: holds a pending entry, loads or shifts from its neighbor.
// ----------------------------------------------------------------------------
module dss_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            clear,
  input  logic            load,
  input  dss_pkg::entry_t load_entry,
  input  logic            shift,
  input  dss_pkg::entry_t shift_in,
  output dss_pkg::entry_t data
);
  import dss_pkg::*;

  entry_t data_next;

  always_comb begin
    data_next = data;
    if (load) begin
      data_next = load_entry;
    end else if (shift) begin
      data_next = shift_in;
    end
    if (clear) begin
      data_next.valid = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    data.slot  <= data_next.slot;
    data.track <= data_next.track;
    if (rst) begin
      data.valid <= 1'b0;
    end else begin
      data.valid <= data_next.valid;
    end
  end
endmodule

### rtl/dss_pick.sv
// ----------------------------------------------------------------------------
// dss_pick
// Candidate trackers fed by the ring head, one entry per cycle while the ring shifts (held when it stalls).
// ----------------------------------------------------------------------------
module dss_pick (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     en,
  input  logic                     first,
  input  dss_pkg::entry_t          head_entry,
  input  logic [dss_pkg::IDX_W-1:0]   svc_idx,
  input  logic [dss_pkg::TRACK_W-1:0] head_pos,
  output dss_pkg::pick_t           pick_next
);
  import dss_pkg::*;

  pick_t pick, base;
  logic cand, up, dn;
  logic [TRACK_W-1:0] g;

  always_comb begin
    base = pick;
    if (first) begin
      base.fu = 1'b0;
      base.fd = 1'b0;
      base.fm = 1'b0;
    end
    cand = head_entry.valid && (head_entry.slot >= svc_idx);
    up = head_entry.track >= head_pos;
    dn = head_entry.track <= head_pos;
    g = up ? head_entry.track - head_pos : head_pos - head_entry.track;
    pick_next = base;
    if (cand && up && (!base.fu || g < base.gu ||
        (g == base.gu && head_entry.slot < base.su))) begin
      pick_next.fu = 1'b1;
      pick_next.gu = g;
      pick_next.su = head_entry.slot;
      pick_next.pu = head_entry.track;
    end
    if (cand && dn && (!base.fd || g < base.gd ||
        (g == base.gd && head_entry.slot < base.sd))) begin
      pick_next.fd = 1'b1;
      pick_next.gd = g;
      pick_next.sd = head_entry.slot;
      pick_next.pd = head_entry.track;
    end
    if (cand && (!base.fm || head_entry.track < base.pm ||
        (head_entry.track == base.pm && head_entry.slot < base.sm))) begin
      pick_next.fm = 1'b1;
      pick_next.pm = head_entry.track;
      pick_next.sm = head_entry.slot;
    end
    if (cand && head_entry.slot == svc_idx) begin
      pick_next.pc = head_entry.track;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pick <= '0;
    end else if (en) begin
      pick <= pick_next;
    end
  end
endmodule

### rtl/disk_seek_scheduler_top.sv
// ----------------------------------------------------------------------------
// disk_seek_scheduler_top
// FIFO / SSTF / SCAN / C-SCAN seek scheduler over a ring of request cells.
// ----------------------------------------------------------------------------
//  channel  dir  transaction
//  req      in   one track request, last_request closes the batch
//  svc      out  one service: track, index, cumulative travel, last flag
//  cfg      in   register write, index 0 mode, 1 start_track
//
//  A request is taken whenever one is offered while loading. Each service is
//  one full revolution of the 64-cell ring. Synchronous reset empties the
//  ring. A result waiting in the output register holds the ring at the end
//  of the next revolution.
// ----------------------------------------------------------------------------
module disk_seek_scheduler_top (
  input  logic        clk,
  input  logic        rst,
  dss_req_if.sink     req,
  dss_svc_if.source   svc,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [6:0]  cfg_data
);
  import dss_pkg::*;

  state_t state;
  mode_t mode;
  logic [TRACK_W-1:0] start_track, head_pos;
  logic sweep_up;
  logic [DIST_W-1:0] travel;
  logic [CNT_W-1:0] count;
  logic [IDX_W-1:0] cyc, svc_idx, sw_a, sw_b;
  entry_t cells [MAX_REQ];
  entry_t head_entry, load_entry;
  pick_t pick_next;
  logic shift, last_cyc, stall, pass_done, accept, close, clear_all;
  logic [TRACK_W-1:0] sel_track, sel_gap, wrap;
  logic [IDX_W-1:0] sel_slot;
  logic use_up, flip;
  logic [DIST_W:0] sum;
  logic [DIST_W-1:0] travel_new;
  logic batch_end;

  assign req.ready = (state == ST_LOAD);
  assign accept = req.valid && req.ready;
  assign close = accept && (req.last_request || count == CNT_W'(MAX_REQ - 1));
  assign last_cyc = (cyc == IDX_W'(MAX_REQ - 1));
  assign stall = last_cyc && svc.valid && !svc.ready;
  assign shift = (state == ST_SERVE) && !stall;
  assign pass_done = shift && last_cyc;
  assign batch_end = (CNT_W'(svc_idx) + 1'b1 == count);
  assign clear_all = pass_done && batch_end;

  always_comb begin
    head_entry = cells[0];
    if (cells[0].slot == sw_a) begin
      head_entry.slot = sw_b;
    end else if (cells[0].slot == sw_b) begin
      head_entry.slot = sw_a;
    end
    load_entry.valid = 1'b1;
    load_entry.slot  = count[IDX_W-1:0];
    load_entry.track = req.request_track;
  end

  for (genvar k = 0; k < MAX_REQ; k++) begin : g_ring
    dss_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .clear      (clear_all),
      .load       (accept && count[IDX_W-1:0] == IDX_W'(k)),
      .load_entry (load_entry),
      .shift      (shift),
      .shift_in   ((k == MAX_REQ - 1) ? head_entry : cells[(k + 1) % MAX_REQ]),
      .data       (cells[k])
    );
  end

  dss_pick u_pick (
    .clk        (clk),
    .rst        (rst),
    .en         (shift),
    .first      (cyc == '0),
    .head_entry (head_entry),
    .svc_idx    (svc_idx),
    .head_pos   (head_pos),
    .pick_next  (pick_next)
  );

  always_comb begin
    use_up = 1'b0;
    flip = 1'b0;
    wrap = '0;
    sel_slot = svc_idx;
    sel_track = pick_next.pc;
    sel_gap = (pick_next.pc >= head_pos) ? pick_next.pc - head_pos
                                         : head_pos - pick_next.pc;
    unique case (mode)
      MODE_FIFO: begin
      end
      MODE_SSTF: begin
        if (pick_next.fu && pick_next.fd) begin
          use_up = (pick_next.gu < pick_next.gd) ||
                   (pick_next.gu == pick_next.gd && pick_next.su < pick_next.sd);
        end else begin
          use_up = pick_next.fu;
        end
      end
      MODE_SCAN: begin
        flip = sweep_up ? !pick_next.fu : !pick_next.fd;
        use_up = sweep_up ^ flip;
      end
      MODE_CSCAN: begin
        use_up = pick_next.fu;
      end
      default: begin
      end
    endcase
    if (mode != MODE_FIFO) begin
      if (mode == MODE_CSCAN && !pick_next.fu) begin
        wrap = head_pos;
        sel_slot = pick_next.sm;
        sel_track = pick_next.pm;
        sel_gap = pick_next.pm;
      end else if (use_up) begin
        sel_slot = pick_next.su;
        sel_track = pick_next.pu;
        sel_gap = pick_next.gu;
      end else begin
        sel_slot = pick_next.sd;
        sel_track = pick_next.pd;
        sel_gap = pick_next.gd;
      end
    end
    sum = {1'b0, travel} + (DIST_W + 1)'(wrap) + (DIST_W + 1)'(sel_gap);
    travel_new = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_LOAD;
      mode <= MODE_FIFO;
      start_track <= START_RESET;
      head_pos <= START_RESET;
      sweep_up <= 1'b1;
      travel <= '0;
      count <= '0;
      cyc <= '0;
      svc_idx <= '0;
      sw_a <= '0;
      sw_b <= '0;
      svc.valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_MODE) begin
          mode <= mode_t'(cfg_data[MODE_W-1:0]);
        end else begin
          start_track <= cfg_data;
        end
      end
      if (svc.valid && svc.ready) begin
        svc.valid <= 1'b0;
      end
      if (accept) begin
        count <= count + 1'b1;
      end
      if (close) begin
        state <= ST_SERVE;
        head_pos <= start_track;
        sweep_up <= 1'b1;
        travel <= '0;
        cyc <= '0;
        svc_idx <= '0;
        sw_a <= '0;
        sw_b <= '0;
      end
      if (shift) begin
        cyc <= cyc + 1'b1;
      end
      if (pass_done) begin
        svc.valid <= 1'b1;
        head_pos <= sel_track;
        travel <= travel_new;
        if (mode == MODE_SCAN && flip) begin
          sweep_up <= !sweep_up;
        end
        sw_a <= svc_idx;
        sw_b <= sel_slot;
        svc_idx <= svc_idx + 1'b1;
        if (batch_end) begin
          state <= ST_LOAD;
          count <= '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pass_done) begin
      svc.served_track <= sel_track;
      svc.service_index <= svc_idx;
      svc.cumulative_distance <= travel_new;
      svc.last_service <= batch_end;
    end
  end

`ifndef SYNTH
  a_no_drop: assert property (@(posedge clk) disable iff (rst)
    svc.valid && !svc.ready |=> svc.valid && $stable(svc.served_track))
    else $error("pending result lost");
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    state == ST_LOAD |-> count < CNT_W'(MAX_REQ))
    else $error("request count overrun");
  a_serve_bound: assert property (@(posedge clk) disable iff (rst)
    state == ST_SERVE |-> CNT_W'(svc_idx) < count)
    else $error("service index beyond batch");
  a_close_serve: assert property (@(posedge clk) disable iff (rst)
    close |=> state == ST_SERVE && cyc == '0)
    else $error("batch close did not start service");
`endif
endmodule

### tb/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Feeds track request batches to the seek scheduler under all four modes and
// several start tracks, predicts the service order with travel totals, and
// checks every service transaction. Both channels idle at random; the result
// side also holds off for a long stretch so that the request side stalls.
// ----------------------------------------------------------------------------
module testbench;
  import dss_pkg::*;

  typedef struct packed {
    logic [TRACK_W-1:0] track;
    logic [IDX_W-1:0]   index;
    logic [DIST_W-1:0]  total;
    logic               last;
  } service_t;

  typedef struct {
    mode_t              m;
    logic [TRACK_W-1:0] trk;
    logic               lst;
    logic               chk;
    logic [TRACK_W-1:0] etrk;
    logic [DIST_W-1:0]  edist;
  } row_t;

  localparam int DIRECTED = 18;
  localparam int WATCHDOG = 6000;
  localparam int HOLD_CYCLES = 400;
  localparam int TARGET_ITEMS = 300;

  logic clk;
  logic rst;
  logic cfg_we;
  logic cfg_index;
  logic [6:0] cfg_data;

  dss_req_if req ();
  dss_svc_if svc ();

  disk_seek_scheduler_top dut (
    .clk(clk), .rst(rst), .req(req.sink), .svc(svc.source),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  service_t           service_q[$];
  logic [TRACK_W-1:0] pending[MAX_REQ];
  int                 pending_cnt;
  mode_t              sched_mode;
  logic [TRACK_W-1:0] start_pos;
  int                 fails;
  int                 accepted;
  int                 stall_cnt;
  bit                 quiet;
  bit                 hold_req;

  row_t rows[DIRECTED] = '{
    '{MODE_FIFO, 7'd50, 1'b1, 1'b1, 7'd50, 14'd0},
    '{MODE_FIFO, 7'd0, 1'b1, 1'b1, 7'd0, 14'd50},
    '{MODE_FIFO, 7'd127, 1'b1, 1'b1, 7'd127, 14'd77},
    '{MODE_FIFO, 7'd10, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_FIFO, 7'd90, 1'b1, 1'b0, 7'd0, 14'd0},
    '{MODE_SSTF, 7'd60, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_SSTF, 7'd40, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_SSTF, 7'd45, 1'b1, 1'b0, 7'd0, 14'd0},
    '{MODE_SSTF, 7'd40, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_SSTF, 7'd60, 1'b1, 1'b0, 7'd0, 14'd0},
    '{MODE_SCAN, 7'd70, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_SCAN, 7'd20, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_SCAN, 7'd100, 1'b1, 1'b0, 7'd0, 14'd0},
    '{MODE_SCAN, 7'd10, 1'b1, 1'b1, 7'd10, 14'd40},
    '{MODE_CSCAN, 7'd70, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_CSCAN, 7'd20, 1'b0, 1'b0, 7'd0, 14'd0},
    '{MODE_CSCAN, 7'd100, 1'b1, 1'b0, 7'd0, 14'd0},
    '{MODE_CSCAN, 7'd10, 1'b1, 1'b1, 7'd10, 14'd60}
  };

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  function automatic int track_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  function automatic bit nearest_dir(int from, int n, bit up, int head, output int sel);
    bit found;
    int best;
    int d;
    found = 1'b0;
    best = 0;
    sel = from;
    for (int j = from; j < n; j++) begin
      d = track_gap(int'(pending[j]), head);
      if ((up ? (int'(pending[j]) >= head) : (int'(pending[j]) <= head)) &&
          (!found || d < best)) begin
        found = 1'b1;
        best = d;
        sel = j;
      end
    end
    return found;
  endfunction

  function automatic int add_travel(int total, int d);
    return (total + d > int'(DIST_MAX)) ? int'(DIST_MAX) : total + d;
  endfunction

  task automatic schedule_request(logic [TRACK_W-1:0] trk, logic lst);
    int n;
    int head;
    int travel;
    int sel;
    bit up;
    logic [TRACK_W-1:0] tmp;
    service_t s;
    if (pending_cnt >= MAX_REQ) pending_cnt = 0;
    pending[pending_cnt] = trk;
    pending_cnt++;
    if (!lst && pending_cnt < MAX_REQ) return;
    n = pending_cnt;
    head = int'(start_pos);
    up = 1'b1;
    travel = 0;
    for (int i = 0; i < n; i++) begin
      sel = i;
      case (sched_mode)
        MODE_SSTF: begin
          for (int j = i + 1; j < n; j++)
            if (track_gap(int'(pending[j]), head) < track_gap(int'(pending[sel]), head))
              sel = j;
        end
        MODE_SCAN: begin
          if (!nearest_dir(i, n, up, head, sel)) begin
            up = !up;
            void'(nearest_dir(i, n, up, head, sel));
          end
        end
        MODE_CSCAN: begin
          if (!nearest_dir(i, n, 1'b1, head, sel)) begin
            travel = add_travel(travel, head);
            head = 0;
            void'(nearest_dir(i, n, 1'b1, head, sel));
          end
        end
        default: ;
      endcase
      travel = add_travel(travel, track_gap(head, int'(pending[sel])));
      head = int'(pending[sel]);
      tmp = pending[i];
      pending[i] = pending[sel];
      pending[sel] = tmp;
      s.track = TRACK_W'(head);
      s.index = IDX_W'(i);
      s.total = DIST_W'(travel);
      s.last = (i + 1 == n);
      service_q.push_back(s);
    end
    pending_cnt = 0;
  endtask

  task automatic report(string field, int got, int want);
    $display("mismatch %s: got %0d, expected %0d", field, got, want);
    fails++;
  endtask

  task automatic write_reg(reg_idx_t idx, logic [6:0] data);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic drain();
    req.valid <= 1'b0;
    while (service_q.size() != 0) @(negedge clk);
    repeat (150) @(negedge clk);
  endtask

  task automatic set_mode(mode_t m);
    write_reg(REG_MODE, 7'(m));
    sched_mode = m;
  endtask

  task automatic set_start(logic [6:0] t);
    write_reg(REG_START, t);
    start_pos = t;
  endtask

  task automatic send_request(logic [TRACK_W-1:0] trk, logic lst);
    while (!quiet && $urandom_range(99) < 8) begin
      req.valid <= 1'b0;
      @(negedge clk);
    end
    req.valid <= 1'b1;
    req.request_track <= trk;
    req.last_request <= lst;
    do @(posedge clk); while (!req.ready);
    schedule_request(trk, lst);
    accepted++;
    @(negedge clk);
  endtask

  function automatic logic [TRACK_W-1:0] pick_track();
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 7'd127 : 7'd0;
    return TRACK_W'($urandom_range(127));
  endfunction

  always @(negedge clk) begin
    if (hold_req) begin
      hold_req <= 1'b0;
      svc.ready <= 1'b0;
      repeat (HOLD_CYCLES) @(negedge clk);
    end
    svc.ready <= quiet || ($urandom_range(99) >= 8);
  end

  always @(posedge clk) begin
    service_t want;
    if (!rst && svc.valid && svc.ready) begin
      if (service_q.size() == 0) begin
        report("unexpected service, track", svc.served_track, -1);
      end else begin
        want = service_q.pop_front();
        if (svc.served_track !== want.track) report("track", svc.served_track, want.track);
        if (svc.service_index !== want.index) report("index", svc.service_index, want.index);
        if (svc.cumulative_distance !== want.total)
          report("distance", svc.cumulative_distance, want.total);
        if (svc.last_service !== want.last) report("last", svc.last_service, want.last);
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (req.valid && req.ready) || (svc.valid && svc.ready)) begin
      stall_cnt <= 0;
    end else if (stall_cnt >= WATCHDOG) begin
      $display("Some tests failed");
      $finish;
    end else begin
      stall_cnt <= stall_cnt + 1;
    end
  end

  initial begin
    int size;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = REG_MODE;
    cfg_data = '0;
    req.valid = 1'b0;
    req.request_track = '0;
    req.last_request = 1'b0;
    svc.ready = 1'b0;
    fails = 0;
    accepted = 0;
    stall_cnt = 0;
    quiet = 1'b0;
    hold_req = 1'b0;
    pending_cnt = 0;
    sched_mode = MODE_FIFO;
    start_pos = START_RESET;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    for (int r = 0; r < DIRECTED; r++) begin
      if (rows[r].m != sched_mode) begin
        drain();
        set_mode(rows[r].m);
      end
      send_request(rows[r].trk, rows[r].lst);
      if (rows[r].chk) begin
        service_q[service_q.size() - 1].track = rows[r].etrk;
        service_q[service_q.size() - 1].total = rows[r].edist;
      end
    end

    for (int ph = 0; accepted < TARGET_ITEMS; ph++) begin
      drain();
      set_mode(ph < 4 ? mode_t'(ph) : mode_t'($urandom_range(3)));
      set_start(ph == 0 ? 7'd0 : ph == 1 ? 7'd127 : ph == 5 ? 7'd50 : pick_track());
      quiet = (ph == 3);
      if (ph == 2) hold_req = 1'b1;
      for (int b = (ph == 2) ? 1 : $urandom_range(4, 1);
           b > 0 && accepted < TARGET_ITEMS; b--) begin
        size = (ph == 2 || $urandom_range(19) == 0) ? MAX_REQ : $urandom_range(8, 1);
        for (int k = 0; k < size; k++)
          send_request(pick_track(),
                       (k == size - 1) && (size < MAX_REQ || $urandom_range(1)));
      end
      if ($urandom_range(3) == 0)
        for (int k = $urandom_range(5, 1); k > 0; k--) send_request(pick_track(), 1'b0);
    end
    quiet = 1'b0;
    send_request(pick_track(), 1'b1);
    req.valid <= 1'b0;
    while (service_q.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
    if (fails == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end
endmodule

### disk_seek_scheduler_top.f
rtl/dss_pkg.sv
rtl/dss_if.sv
rtl/dss_cell.sv
rtl/dss_pick.sv
rtl/disk_seek_scheduler_top.sv
tb/testbench.sv
